// ===== rtl/cssc_pkg.sv =====
// Shared types and command/status codes for the character strand search unit.
`timescale 1ns / 1ps
package cssc_pkg;

   // Command codes
   localparam logic [2:0] CMD_CLEAR      = 3'd0;
   localparam logic [2:0] CMD_APPEND     = 3'd1;
   localparam logic [2:0] CMD_SET        = 3'd2;
   localparam logic [2:0] CMD_GET        = 3'd3;
   localparam logic [2:0] CMD_SEARCH     = 3'd4;
   localparam logic [2:0] CMD_CLEAVE     = 3'd5;
   localparam logic [2:0] CMD_CLEAVE_ALL = 3'd6;
   localparam logic [2:0] CMD_COUNT      = 3'd7;

   // Status codes
   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_RANGE     = 2'd1;
   localparam logic [1:0] STS_NOT_FOUND = 2'd2;

   // Configuration register indexes
   localparam logic CSR_PATTERN_CHARS  = 1'b0;
   localparam logic CSR_PATTERN_LENGTH = 1'b1;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] base_char;
      logic [8:0] position;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] result_char;
      logic [8:0] result_index;
      logic [8:0] strand_length;
      logic [8:0] char_count;
   } rsp_type;

endpackage

// ===== rtl/char_strand_search_cleave.sv =====
// Commands pass idle, execute and response; get adds a read wait, search/count scan,
// cleave scans for two matches then copies the tail (one byte per cycle each).
// Cleave all repeats scan and copy per cleaved pair; one command in flight at a time.
// The single-read-port strand memory, one byte per cycle, sets the scan and copy rate.
// Reset (synchronous, active high) zeroes the length and pattern registers; the
// strand memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
module char_strand_search_cleave #(
   parameter int STRAND_DEPTH = 256,
   parameter int PATTERN_MAX  = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cssc_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cssc_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [63:0]       csr_data
);

   localparam int AW = $clog2(STRAND_DEPTH);
   localparam int LW = $clog2(STRAND_DEPTH + 1);
   localparam int CW = (LW > 9) ? LW : 9;
   localparam logic [3:0] PAT_MAX = 4'(PATTERN_MAX);
   localparam logic [LW-1:0] DEPTH_L = LW'(STRAND_DEPTH);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_GETW = 3'd2;
   localparam logic [2:0] ST_SCAN = 3'd3;
   localparam logic [2:0] ST_MOVE = 3'd4;
   localparam logic [2:0] ST_RESP = 3'd5;

   logic [7:0]        mem [STRAND_DEPTH];
   logic [2:0]        state_ff, state_in;
   cssc_pkg::req_type cmd_ff;
   logic [63:0]       pat_chars_ff;
   logic [3:0]        pat_len_ff;
   logic [LW-1:0]     len_ff, len_in;
   logic [LW-1:0]     rd_addr_ff, rd_addr_in;
   logic [LW-1:0]     wr_addr_ff, wr_addr_in;
   logic [LW-1:0]     q_idx_ff;
   logic [LW-1:0]     first_end_ff, first_end_in;
   logic [LW-1:0]     cut_end_ff, cut_end_in;
   logic [LW-1:0]     count_ff, count_in;
   logic [LW-1:0]     res_index_ff, res_index_in;
   logic [1:0]        res_status_ff, res_status_in;
   logic [7:0]        res_char_ff, res_char_in;
   logic              q_vld_ff;
   logic [7:0]        mem_q_ff;
   logic [7:0]        win_ff [PATTERN_MAX];
   logic [7:0]        win_n [PATTERN_MAX];
   logic [3:0]        seen_ff, seen_in, seen_n;
   logic              phase_ff, phase_in;
   logic              any_ff, any_in;
   logic              rsp_valid_ff;
   cssc_pkg::rsp_type rsp_ff;

   logic [3:0]        n;
   logic [3:0]        sel;
   logic              hit, hit_stop;
   logic              rd_en, wr_en;
   logic [AW-1:0]     rd_sel, wr_sel;
   logic [7:0]        wr_data;
   logic [CW-1:0]     pos_w, len_w;
   logic [LW-1:0]     q_end, match_start;
   logic              rsp_load;
   logic [CW-1:0]     idx_w, len_o, cnt_w;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign pos_w = CW'(cmd_ff.position);
   assign len_w = CW'(len_ff);
   assign q_end = q_idx_ff + LW'(1);
   assign rsp_load = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ready);

   // Pattern window compare: newest byte in slot 0
   always_comb begin
      n = (pat_len_ff > PAT_MAX) ? PAT_MAX : pat_len_ff;
      win_n[0] = mem_q_ff;
      for (int k = 1; k < PATTERN_MAX; k++) begin
         win_n[k] = win_ff[k-1];
      end
      seen_n = (seen_ff >= PAT_MAX) ? PAT_MAX : seen_ff + 4'd1;
      sel = 4'd0;
      hit = (state_ff == ST_SCAN) && q_vld_ff && (cmd_ff.cmd != cssc_pkg::CMD_COUNT)
            && (n != 4'd0) && (seen_n >= n);
      for (int k = 0; k < PATTERN_MAX; k++) begin
         if (4'(k) < n) begin
            sel = n - 4'd1 - 4'(k);
            if (win_n[k] != pat_chars_ff[{sel[2:0], 3'b000} +: 8]) hit = 1'b0;
         end
      end
      hit_stop = hit && ((cmd_ff.cmd == cssc_pkg::CMD_SEARCH) || phase_ff);
      match_start = q_end - LW'(n);
   end

   // Command sequencer
   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      rd_addr_in    = rd_addr_ff;
      wr_addr_in    = wr_addr_ff;
      first_end_in  = first_end_ff;
      cut_end_in    = cut_end_ff;
      count_in      = count_ff;
      res_index_in  = res_index_ff;
      res_status_in = res_status_ff;
      res_char_in   = res_char_ff;
      seen_in       = seen_ff;
      phase_in      = phase_ff;
      any_in        = any_ff;
      rd_en         = 1'b0;
      rd_sel        = rd_addr_ff[AW-1:0];
      wr_en         = 1'b0;
      wr_sel        = wr_addr_ff[AW-1:0];
      wr_data       = mem_q_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            res_status_in = cssc_pkg::STS_OK;
            res_char_in   = 8'd0;
            res_index_in  = '0;
            count_in      = '0;
            seen_in       = 4'd0;
            phase_in      = 1'b0;
            any_in        = 1'b0;
            state_in      = ST_RESP;
            unique case (cmd_ff.cmd)
               cssc_pkg::CMD_CLEAR: len_in = '0;
               cssc_pkg::CMD_APPEND: begin
                  if (len_ff == DEPTH_L) begin
                     res_status_in = cssc_pkg::STS_RANGE;
                  end else begin
                     wr_en   = 1'b1;
                     wr_sel  = len_ff[AW-1:0];
                     wr_data = cmd_ff.base_char;
                     len_in  = len_ff + LW'(1);
                  end
               end
               cssc_pkg::CMD_SET: begin
                  if (pos_w < len_w) begin
                     wr_en   = 1'b1;
                     wr_sel  = pos_w[AW-1:0];
                     wr_data = cmd_ff.base_char;
                  end else begin
                     res_status_in = cssc_pkg::STS_RANGE;
                  end
               end
               cssc_pkg::CMD_GET: begin
                  if (pos_w < len_w) begin
                     rd_en    = 1'b1;
                     rd_sel   = pos_w[AW-1:0];
                     state_in = ST_GETW;
                  end else begin
                     res_status_in = cssc_pkg::STS_RANGE;
                  end
               end
               cssc_pkg::CMD_SEARCH, cssc_pkg::CMD_CLEAVE: begin
                  rd_addr_in = (pos_w >= len_w) ? len_ff : pos_w[LW-1:0];
                  state_in   = ST_SCAN;
               end
               default: begin
                  // cleave all and count scan from the start
                  rd_addr_in = '0;
                  state_in   = ST_SCAN;
               end
            endcase
         end
         ST_GETW: begin
            res_char_in = mem_q_ff;
            state_in    = ST_RESP;
         end
         ST_SCAN: begin
            rd_en = (rd_addr_ff < len_ff) && !hit_stop;
            if (rd_en) rd_addr_in = rd_addr_ff + LW'(1);
            if (q_vld_ff) begin
               seen_in = seen_n;
               if ((cmd_ff.cmd == cssc_pkg::CMD_COUNT) && (mem_q_ff == cmd_ff.base_char))
                  count_in = count_ff + LW'(1);
            end
            priority if (hit && !hit_stop) begin
               // first occurrence found; second must start at or after its end
               first_end_in = q_end;
               phase_in     = 1'b1;
               seen_in      = 4'd0;
            end else if (hit_stop) begin
               if (cmd_ff.cmd == cssc_pkg::CMD_SEARCH) begin
                  res_index_in = match_start;
                  state_in     = ST_RESP;
               end else begin
                  cut_end_in = q_end;
                  rd_addr_in = q_end;
                  wr_addr_in = first_end_ff;
                  state_in   = ST_MOVE;
               end
            end else if (!q_vld_ff && (rd_addr_ff == len_ff)) begin
               state_in = ST_RESP;
               if (cmd_ff.cmd == cssc_pkg::CMD_COUNT)
                  res_status_in = cssc_pkg::STS_OK;
               else if ((cmd_ff.cmd == cssc_pkg::CMD_CLEAVE_ALL) && any_ff)
                  res_status_in = cssc_pkg::STS_OK;
               else
                  res_status_in = cssc_pkg::STS_NOT_FOUND;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_MOVE: begin
            // tail copy: read source, write destination in the next cycle
            rd_en = (rd_addr_ff < len_ff);
            if (rd_en) rd_addr_in = rd_addr_ff + LW'(1);
            if (q_vld_ff) begin
               wr_en      = 1'b1;
               wr_addr_in = wr_addr_ff + LW'(1);
            end
            if (!q_vld_ff && (rd_addr_ff == len_ff)) begin
               len_in = len_ff - cut_end_ff + first_end_ff;
               if (cmd_ff.cmd == cssc_pkg::CMD_CLEAVE) begin
                  res_index_in = first_end_ff;
                  state_in     = ST_RESP;
               end else begin
                  any_in     = 1'b1;
                  rd_addr_in = first_end_ff;
                  phase_in   = 1'b0;
                  seen_in    = 4'd0;
                  state_in   = ST_SCAN;
               end
            end
         end
         ST_RESP: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output field packing
   assign idx_w = CW'(res_index_ff);
   assign len_o = CW'(len_ff);
   assign cnt_w = CW'(count_ff);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         pat_chars_ff <= '0;
         pat_len_ff   <= 4'd0;
         q_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         q_vld_ff <= rd_en;
         if (csr_valid) begin
            if (csr_index == cssc_pkg::CSR_PATTERN_CHARS) pat_chars_ff <= csr_data;
            else pat_len_ff <= csr_data[3:0];
         end
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) cmd_ff <= req_payload;
      rd_addr_ff    <= rd_addr_in;
      wr_addr_ff    <= wr_addr_in;
      q_idx_ff      <= rd_addr_ff;
      first_end_ff  <= first_end_in;
      cut_end_ff    <= cut_end_in;
      count_ff      <= count_in;
      res_index_ff  <= res_index_in;
      res_status_ff <= res_status_in;
      res_char_ff   <= res_char_in;
      seen_ff       <= seen_in;
      phase_ff      <= phase_in;
      any_ff        <= any_in;
      if ((state_ff == ST_SCAN) && q_vld_ff) begin
         for (int k = 0; k < PATTERN_MAX; k++) win_ff[k] <= win_n[k];
      end
      if (rsp_load) begin
         rsp_ff.status        <= res_status_ff;
         rsp_ff.result_char   <= res_char_ff;
         rsp_ff.result_index  <= idx_w[8:0];
         rsp_ff.strand_length <= len_o[8:0];
         rsp_ff.char_count    <= cnt_w[8:0];
      end
   end

   // Strand memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_sel] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) mem_q_ff <= mem[rd_sel];
   end

   // Checks
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= DEPTH_L)
      else $error("strand length exceeds depth");

   a_move_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOVE) |-> (wr_addr_ff < rd_addr_ff))
      else $error("tail copy destination not below source");

   a_read_ctx: assert property (@(posedge clock) disable iff (reset)
      q_vld_ff |-> (state_ff == ST_SCAN || state_ff == ST_MOVE || state_ff == ST_GETW))
      else $error("read data returned outside a reading state");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second transaction accepted while busy");

endmodule
